@@ rtl/bls_pkg.sv @@
// bls_pkg: shared constants and types for the bresenham line stepper
// used by every module under rtl, depends on nothing
package bls_pkg;

    localparam int CoordBits  = 10;
    localparam int DecBits    = CoordBits + 3;
    localparam int CmdDepth   = 4;
    localparam int CmdPtrBits = $clog2(CmdDepth);

    localparam logic ReqStart = 1'b0;
    localparam logic ReqStep  = 1'b1;

    typedef logic [CoordBits-1:0]      coord_t;
    typedef logic signed [DecBits-1:0] decision_t;

    // classified request handed from front to back
    typedef struct packed {
        logic   is_start;
        coord_t start_x;
        coord_t start_y;
        coord_t stop_major;
        coord_t delta_major;
        coord_t delta_minor;
        logic   steep;
        logic   minor_dir_down;
    } cmd_t;

endpackage

@@ rtl/bls_front.sv @@
// bls_front: classifies a request and sets up a new line from its endpoints
// depends on bls_pkg
module bls_front
(
    input  logic            req_type,
    input  bls_pkg::coord_t x_start,
    input  bls_pkg::coord_t y_start,
    input  bls_pkg::coord_t x_end,
    input  bls_pkg::coord_t y_end,
    output bls_pkg::cmd_t   cmd
);

    logic            x_gt;
    logic            y_gt;
    logic            steep;
    logic            swap;
    bls_pkg::coord_t dx;
    bls_pkg::coord_t dy;
    bls_pkg::coord_t ax;
    bls_pkg::coord_t ay;
    bls_pkg::coord_t bx;
    bls_pkg::coord_t by;

    always_comb
    begin
        x_gt  = x_start > x_end;
        y_gt  = y_start > y_end;
        dx    = x_gt ? (x_start - x_end) : (x_end - x_start);
        dy    = y_gt ? (y_start - y_end) : (y_end - y_start);
        steep = dy > dx;
        swap  = steep ? y_gt : x_gt;
        ax    = swap ? x_end   : x_start;
        ay    = swap ? y_end   : y_start;
        bx    = swap ? x_start : x_end;
        by    = swap ? y_start : y_end;

        cmd.is_start       = (req_type == bls_pkg::ReqStart);
        cmd.start_x        = ax;
        cmd.start_y        = ay;
        cmd.steep          = steep;
        cmd.stop_major     = steep ? by : bx;
        cmd.delta_major    = steep ? dy : dx;
        cmd.delta_minor    = steep ? dx : dy;
        cmd.minor_dir_down = steep ? (bx < ax) : (by < ay);
    end

endmodule

@@ rtl/bls_cmd_fifo.sv @@
// bls_cmd_fifo: short command queue between front and back
// depends on bls_pkg
module bls_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bls_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output bls_pkg::cmd_t pop_data,
    output logic          not_empty
);

    bls_pkg::cmd_t                       entries_reg [bls_pkg::CmdDepth];
    logic [bls_pkg::CmdPtrBits-1:0]      wr_ptr_reg;
    logic [bls_pkg::CmdPtrBits-1:0]      wr_ptr_next;
    logic [bls_pkg::CmdPtrBits-1:0]      rd_ptr_reg;
    logic [bls_pkg::CmdPtrBits-1:0]      rd_ptr_next;
    logic [bls_pkg::CmdPtrBits:0]        count_reg;
    logic [bls_pkg::CmdPtrBits:0]        count_next;

    localparam logic [bls_pkg::CmdPtrBits:0] FullCount =
        (bls_pkg::CmdPtrBits+1)'(bls_pkg::CmdDepth);

    assign full      = (count_reg == FullCount);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCount)
        else $error("command queue count past depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty command queue");

endmodule

@@ rtl/bls_back.sv @@
// bls_back: line state, bresenham stepping and the result register
// depends on bls_pkg
module bls_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  bls_pkg::cmd_t   cmd,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output bls_pkg::coord_t pixel_x,
    output bls_pkg::coord_t pixel_y,
    output logic            pixel_valid,
    output logic            last_pixel
);

    bls_pkg::coord_t   cur_x_reg;
    bls_pkg::coord_t   cur_x_next;
    bls_pkg::coord_t   cur_y_reg;
    bls_pkg::coord_t   cur_y_next;
    bls_pkg::coord_t   stop_major_reg;
    bls_pkg::coord_t   stop_major_next;
    bls_pkg::coord_t   delta_major_reg;
    bls_pkg::coord_t   delta_major_next;
    bls_pkg::coord_t   delta_minor_reg;
    bls_pkg::coord_t   delta_minor_next;
    bls_pkg::decision_t decision_reg;
    bls_pkg::decision_t decision_next;
    logic              steep_reg;
    logic              steep_next;
    logic              dir_down_reg;
    logic              dir_down_next;
    logic              busy_reg;
    logic              busy_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    bls_pkg::coord_t   pixel_x_reg;
    bls_pkg::coord_t   pixel_x_next;
    bls_pkg::coord_t   pixel_y_reg;
    bls_pkg::coord_t   pixel_y_next;
    logic              pixel_valid_reg;
    logic              pixel_valid_next;
    logic              last_pixel_reg;
    logic              last_pixel_next;

    logic              fire;
    logic              emit;
    logic              last;
    bls_pkg::coord_t   minor;
    bls_pkg::coord_t   minor_moved;
    bls_pkg::coord_t   major_moved;
    bls_pkg::coord_t   new_x;
    bls_pkg::coord_t   new_y;
    bls_pkg::decision_t two_min;
    bls_pkg::decision_t two_maj;
    bls_pkg::decision_t cmd_two_min;
    bls_pkg::decision_t cmd_two_maj;

    localparam int ExtBits = bls_pkg::DecBits - bls_pkg::CoordBits - 1;

    assign fire        = cmd_valid && (!out_valid_reg || pop);
    assign cmd_pop     = fire;
    assign empty       = !out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_valid = pixel_valid_reg;
    assign last_pixel  = last_pixel_reg;

    always_comb
    begin
        two_min     = $signed({{ExtBits{1'b0}}, delta_minor_reg, 1'b0});
        two_maj     = $signed({{ExtBits{1'b0}}, delta_major_reg, 1'b0});
        cmd_two_min = $signed({{ExtBits{1'b0}}, cmd.delta_minor, 1'b0});
        cmd_two_maj = $signed({{ExtBits{1'b0}}, cmd.delta_major, 1'b0});

        minor       = steep_reg ? cur_x_reg : cur_y_reg;
        minor_moved = dir_down_reg ? minor - 1'b1 : minor + 1'b1;
        major_moved = (steep_reg ? cur_y_reg : cur_x_reg) + 1'b1;

        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        stop_major_next  = stop_major_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        decision_next    = decision_reg;
        steep_next       = steep_reg;
        dir_down_next    = dir_down_reg;
        busy_next        = busy_reg;
        new_x            = '0;
        new_y            = '0;
        emit             = 1'b0;
        last             = 1'b0;

        if (fire && cmd.is_start)
        begin
            // new line, emits its first endpoint
            new_x            = cmd.start_x;
            new_y            = cmd.start_y;
            stop_major_next  = cmd.stop_major;
            delta_major_next = cmd.delta_major;
            delta_minor_next = cmd.delta_minor;
            steep_next       = cmd.steep;
            dir_down_next    = cmd.minor_dir_down;
            decision_next    = cmd_two_min - (cmd_two_maj >>> 1);
            last             = ((cmd.steep ? cmd.start_y : cmd.start_x) == cmd.stop_major);
            emit             = 1'b1;
        end
        else if (fire && busy_reg)
        begin
            if (decision_reg[bls_pkg::DecBits-1])
            begin
                decision_next = decision_reg + two_min;
                new_x         = steep_reg ? cur_x_reg : major_moved;
                new_y         = steep_reg ? major_moved : cur_y_reg;
            end
            else
            begin
                decision_next = decision_reg + two_min - two_maj;
                new_x         = steep_reg ? minor_moved : major_moved;
                new_y         = steep_reg ? major_moved : minor_moved;
            end
            last = (major_moved == stop_major_reg);
            emit = 1'b1;
        end

        if (emit)
        begin
            cur_x_next = new_x;
            cur_y_next = new_y;
            busy_next  = !last;
        end

        out_valid_next   = out_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_valid_next = pixel_valid_reg;
        last_pixel_next  = last_pixel_reg;
        if (fire)
        begin
            out_valid_next   = 1'b1;
            pixel_x_next     = new_x;
            pixel_y_next     = new_y;
            pixel_valid_next = emit;
            last_pixel_next  = last;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            stop_major_reg  <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            decision_reg    <= '0;
            steep_reg       <= 1'b0;
            dir_down_reg    <= 1'b0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            stop_major_reg  <= stop_major_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            decision_reg    <= decision_next;
            steep_reg       <= steep_next;
            dir_down_reg    <= dir_down_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_valid_reg <= pixel_valid_next;
        last_pixel_reg  <= last_pixel_next;
    end

    a_busy_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd.is_start || busy_reg) |=> busy_reg != last_pixel_reg)
        else $error("busy flag disagrees with last pixel");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pixel_valid_reg |->
            !last_pixel_reg && pixel_x_reg == '0 && pixel_y_reg == '0)
        else $error("idle step result not cleared");

    a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
        delta_minor_reg <= delta_major_reg)
        else $error("minor delta exceeds major delta");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg)
        else $error("waiting result dropped");

endmodule

@@ rtl/bresenham_line_stepper.sv @@
// bresenham_line_stepper: top level, front classifier, command queue, back stepper
// depends on bls_pkg, bls_front, bls_cmd_fifo, bls_back
//
// channel   direction  handshake     fields
// request   in         push / full   req_type, x_start, y_start, x_end, y_end
// pixel     out        pop / empty   pixel_x, pixel_y, pixel_valid, last_pixel
//
// one request per cycle sustained while the pixel side pops every result, each giving one pixel result
// a request passes through the command queue and the result register before it shows up on the pixel ports
// the back stepper does one decision add and one coordinate step per cycle while it takes a command
// reset clears the line state to idle, no clearing pass
// the command queue holds four requests while the pixel side stalls
module bresenham_line_stepper
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            req_type,
    input  bls_pkg::coord_t x_start,
    input  bls_pkg::coord_t y_start,
    input  bls_pkg::coord_t x_end,
    input  bls_pkg::coord_t y_end,
    output logic            empty,
    input  logic            pop,
    output bls_pkg::coord_t pixel_x,
    output bls_pkg::coord_t pixel_y,
    output logic            pixel_valid,
    output logic            last_pixel
);

    bls_pkg::cmd_t front_cmd;
    bls_pkg::cmd_t back_cmd;
    logic          cmd_valid;
    logic          cmd_pop;
    logic          in_xfer;

    assign in_xfer = push && !full;

    bls_front u_front
    (
        .req_type (req_type),
        .x_start  (x_start),
        .y_start  (y_start),
        .x_end    (x_end),
        .y_end    (y_end),
        .cmd      (front_cmd)
    );

    bls_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (front_cmd),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (back_cmd),
        .not_empty (cmd_valid)
    );

    bls_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (back_cmd),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_valid (pixel_valid),
        .last_pixel  (last_pixel)
    );

endmodule
